// File: rtl/hj212frc_pkg.sv
// Shared types, constants and helper functions for the HJ212 frame receive checker.
`default_nettype none

package hj212frc_pkg;

    // Field widths of the result transaction.
    localparam int STATUS_W   = 3;
    localparam int DECL_W     = 14;
    localparam int DLEN_W     = 11;
    localparam int CRC_W      = 16;
    localparam int BYTE_W     = 8;
    localparam int TDATA_IN_W = 8;
    localparam int TDATA_W    = 72;

    // Framing constants.
    localparam int              MAX_DATA_DEF = 1024;
    localparam int              WIN_LEN      = 5;
    localparam int              LEN_DIGITS   = 4;
    localparam logic [CRC_W-1:0] CRC_INIT    = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]      CH_HASH      = 8'h23;
    localparam logic [7:0]      CH_CR        = 8'h0D;
    localparam logic [7:0]      CH_LF        = 8'h0A;

    // Receive phase of the deframer.
    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_DATA = 2'd2
    } phase_t;

    // Frame status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_LEN_MISMATCH = 3'd2,
        ST_CRC_MISMATCH = 3'd3,
        ST_TOO_LONG     = 3'd4,
        ST_RESTARTED    = 3'd5
    } status_t;

    // Result kinds carried on tuser.
    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    // One result transaction.
    typedef struct packed {
        kind_t               kind;
        logic                last;
        logic [BYTE_W-1:0]   payload_byte;
        status_t             status;
        logic [DECL_W-1:0]   declared_length;
        logic [DLEN_W-1:0]   data_length;
        logic [CRC_W-1:0]    received_crc;
        logic [CRC_W-1:0]    computed_crc;
    } out_item_t;

    // Byte-wide reflected CRC16 update with polynomial 0xA001.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                   input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = (crc >> 8) ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Hex character decode: bit 4 is set when the character is a hex digit.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h41 + 8'd10)};
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h61 + 8'd10)};
        end
        return r;
    endfunction

    // Parse four hex characters, first character in the low byte; stops at the first non-hex.
    function automatic logic [CRC_W-1:0] parse_crc(input logic [31:0] chars);
        logic [CRC_W-1:0] v;
        logic             stopped;
        logic [4:0]       d;
        v       = '0;
        stopped = 1'b0;
        for (int i = 0; i < 4; i++) begin
            d = hex_digit(chars[i*8 +: 8]);
            if (!stopped && d[4]) begin
                v = {v[CRC_W-5:0], d[3:0]};
            end
            else begin
                stopped = 1'b1;
            end
        end
        return v;
    endfunction

endpackage

`default_nettype wire

// File: rtl/hj212frc_out_buf.sv
// Two-entry output register with skid stage for the result transactions.
`default_nettype none

module hj212frc_out_buf (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    input  wire hj212frc_pkg::out_item_t in_item,
    output logic                        in_ready,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output hj212frc_pkg::out_item_t     out_item
);

    logic                    main_valid_reg;
    logic                    main_valid_next;
    hj212frc_pkg::out_item_t main_item_reg;
    hj212frc_pkg::out_item_t main_item_next;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    hj212frc_pkg::out_item_t skid_item_reg;
    hj212frc_pkg::out_item_t skid_item_next;
    logic                    pop;

    // Ready depends only on the skid stage, so no path runs from out_ready to in_ready.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_item  = main_item_reg;
    assign pop       = main_valid_reg && out_ready;

    // Next-state logic for the main and skid entries.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_item_next  = main_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (skid_valid_reg) begin
            if (pop) begin
                main_item_next  = skid_item_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!main_valid_reg || pop) begin
            main_valid_next = in_valid;
            if (in_valid) begin
                main_item_next = in_item;
            end
        end
        else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_item_next  = in_item;
        end
    end

    // Valid flags are cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        main_item_reg <= main_item_next;
        skid_item_reg <= skid_item_next;
    end

endmodule

`default_nettype wire

// File: rtl/hj212_frame_receive_checker.sv
// HJ212 frame receiver: header hunt, length field, payload delay window, CRC16 and status.
//
// Usage:
//   Received bytes enter on the s_t* channel, one byte per transaction. The block
//   drops bytes until "##", reads four ASCII length digits, then passes payload
//   bytes out through a five-byte delay window so that the four hex CRC characters
//   and the CR are held back. Each payload byte leaves on the m_t* channel with
//   m_tuser = 0; the status transaction that closes a frame has m_tuser = 1 and
//   m_tlast = 1. A byte causes at most one result transaction.
//   Results are registered in the output buffer before they are offered on m_tvalid.
//   Throughput: one byte per cycle while s_tready is high; the CRC update is a
//   combinational byte step in the next-state logic of the state registers.
//   Stalls: a two-entry output buffer (output register plus skid entry) keeps
//   s_tready registered; s_tready drops only when both entries hold results,
//   and rises again in the cycle after the receiver takes one.
//   Reset: rst_n clears the frame state to header hunting and empties the
//   output buffer; no clearing pass is needed.
`default_nettype none

module hj212_frame_receive_checker #(
    parameter int MAX_DATA = hj212frc_pkg::MAX_DATA_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // Input byte stream.
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [hj212frc_pkg::TDATA_IN_W-1:0] s_tdata,   // [7:0] in_byte
    // Result stream.
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] payload_byte, [10:8] status, [24:11] declared_length,
    // [35:25] data_length, [51:36] received_crc, [67:52] computed_crc, [71:68] zero
    output logic [hj212frc_pkg::TDATA_W-1:0]       m_tdata,
    output logic [0:0]                             m_tuser,   // [0] out_kind
    output logic                                   m_tlast
);

    localparam int CNT_W = $clog2(MAX_DATA + 1);
    localparam int WIN   = hj212frc_pkg::WIN_LEN;
    localparam int FIL_W = $clog2(WIN + 1);

    // Frame state.
    hj212frc_pkg::phase_t              phase_reg, phase_next;
    logic                              prev_hash_reg, prev_hash_next;
    logic                              prev_cr_reg, prev_cr_next;
    logic [2:0]                        digits_reg, digits_next;
    logic [hj212frc_pkg::DECL_W-1:0]   len_val_reg, len_val_next;
    logic                              len_stop_reg, len_stop_next;
    logic [FIL_W-1:0]                  fill_reg, fill_next;
    logic [hj212frc_pkg::CRC_W-1:0]    crc_reg, crc_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [7:0]                        win_reg [WIN];
    logic [7:0]                        win_next [WIN];

    logic                              accept;
    logic                              res_valid;
    hj212frc_pkg::out_item_t           res_item;
    hj212frc_pkg::out_item_t           buf_item;
    logic                              buf_ready;
    logic [7:0]                        b;
    logic                              is_hash;
    logic                              is_digit;
    logic [2:0]                        digits_inc;
    logic [hj212frc_pkg::CRC_W-1:0]    rx_crc;

    assign b        = s_tdata;
    assign accept   = s_tvalid && buf_ready;
    assign s_tready = buf_ready;
    assign is_hash  = (b == hj212frc_pkg::CH_HASH);
    assign is_digit = (b >= 8'h30) && (b <= 8'h39);
    assign digits_inc = digits_reg + 3'd1;
    assign rx_crc   = hj212frc_pkg::parse_crc({win_reg[3], win_reg[2], win_reg[1], win_reg[0]});

    // Per-byte frame logic: next state and the result it causes.
    always_comb
    begin
        phase_next     = phase_reg;
        prev_hash_next = prev_hash_reg;
        prev_cr_next   = prev_cr_reg;
        digits_next    = digits_reg;
        len_val_next   = len_val_reg;
        len_stop_next  = len_stop_reg;
        fill_next      = fill_reg;
        crc_next       = crc_reg;
        count_next     = count_reg;
        for (int i = 0; i < WIN; i++) begin
            win_next[i] = win_reg[i];
        end
        res_valid                = 1'b0;
        res_item                 = '0;
        res_item.kind            = hj212frc_pkg::KIND_STATUS;
        res_item.last            = 1'b1;
        res_item.status          = hj212frc_pkg::ST_OK;
        res_item.declared_length = len_val_reg;
        res_item.data_length     = hj212frc_pkg::DLEN_W'(count_reg);
        res_item.computed_crc    = crc_reg;

        if (phase_reg != hj212frc_pkg::PH_LEN && phase_reg != hj212frc_pkg::PH_DATA) begin
            // Header hunt.
            if (is_hash && prev_hash_reg) begin
                phase_next     = hj212frc_pkg::PH_LEN;
                prev_hash_next = 1'b0;
                prev_cr_next   = 1'b0;
                digits_next    = '0;
                len_val_next   = '0;
                len_stop_next  = 1'b0;
                fill_next      = '0;
                crc_next       = hj212frc_pkg::CRC_INIT;
                count_next     = '0;
            end
            else begin
                prev_hash_next = is_hash;
            end
        end
        else if (is_hash && prev_hash_reg) begin
            // Fresh header inside a frame.
            res_valid       = 1'b1;
            res_item.status = hj212frc_pkg::ST_RESTARTED;
            phase_next      = hj212frc_pkg::PH_LEN;
            prev_hash_next  = 1'b0;
            prev_cr_next    = 1'b0;
            digits_next     = '0;
            len_val_next    = '0;
            len_stop_next   = 1'b0;
            fill_next       = '0;
            crc_next        = hj212frc_pkg::CRC_INIT;
            count_next      = '0;
        end
        else if (b == hj212frc_pkg::CH_LF && prev_cr_reg) begin
            // End of frame.
            res_valid = 1'b1;
            if (phase_reg == hj212frc_pkg::PH_LEN || fill_reg < FIL_W'(WIN)) begin
                res_item.status = hj212frc_pkg::ST_TOO_SHORT;
            end
            else begin
                res_item.received_crc = rx_crc;
                if (32'(len_val_reg) != 32'(count_reg)) begin
                    res_item.status = hj212frc_pkg::ST_LEN_MISMATCH;
                end
                else if (rx_crc != crc_reg) begin
                    res_item.status = hj212frc_pkg::ST_CRC_MISMATCH;
                end
                else begin
                    res_item.status = hj212frc_pkg::ST_OK;
                end
            end
            phase_next     = hj212frc_pkg::PH_HUNT;
            prev_hash_next = 1'b0;
            prev_cr_next   = 1'b0;
            digits_next    = '0;
            len_val_next   = '0;
            len_stop_next  = 1'b0;
            fill_next      = '0;
            crc_next       = hj212frc_pkg::CRC_INIT;
            count_next     = '0;
        end
        else begin
            prev_hash_next = is_hash;
            prev_cr_next   = (b == hj212frc_pkg::CH_CR);
            if (phase_reg == hj212frc_pkg::PH_LEN) begin
                // Length field, read like atoi.
                if (!len_stop_reg && is_digit) begin
                    len_val_next = hj212frc_pkg::DECL_W'(len_val_reg * 14'd10
                                   + hj212frc_pkg::DECL_W'(b - 8'h30));
                end
                else begin
                    len_stop_next = 1'b1;
                end
                digits_next = digits_inc;
                if (digits_inc >= 3'(hj212frc_pkg::LEN_DIGITS)) begin
                    phase_next = hj212frc_pkg::PH_DATA;
                end
            end
            else if (fill_reg >= FIL_W'(WIN)) begin
                if (count_reg >= CNT_W'(MAX_DATA)) begin
                    // Overlong frame: report and hunt, keeping this byte as a possible '#'.
                    res_valid       = 1'b1;
                    res_item.status = hj212frc_pkg::ST_TOO_LONG;
                    phase_next      = hj212frc_pkg::PH_HUNT;
                    prev_hash_next  = is_hash;
                    prev_cr_next    = 1'b0;
                    digits_next     = '0;
                    len_val_next    = '0;
                    len_stop_next   = 1'b0;
                    fill_next       = '0;
                    crc_next        = hj212frc_pkg::CRC_INIT;
                    count_next      = '0;
                end
                else begin
                    // Oldest window byte leaves as payload.
                    res_valid             = 1'b1;
                    res_item              = '0;
                    res_item.kind         = hj212frc_pkg::KIND_PAYLOAD;
                    res_item.status       = hj212frc_pkg::ST_OK;
                    res_item.payload_byte = win_reg[0];
                    crc_next              = hj212frc_pkg::crc16_byte(crc_reg, win_reg[0]);
                    count_next            = count_reg + CNT_W'(1);
                    for (int i = 0; i < WIN - 1; i++) begin
                        win_next[i] = win_reg[i+1];
                    end
                    win_next[WIN-1] = b;
                end
            end
            else begin
                // Window still filling; after WIN shifts the first byte sits at the head.
                for (int i = 0; i < WIN - 1; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[WIN-1] = b;
                fill_next       = fill_reg + FIL_W'(1);
            end
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg     <= hj212frc_pkg::PH_HUNT;
            prev_hash_reg <= 1'b0;
            prev_cr_reg   <= 1'b0;
            digits_reg    <= '0;
            len_val_reg   <= '0;
            len_stop_reg  <= 1'b0;
            fill_reg      <= '0;
            crc_reg       <= hj212frc_pkg::CRC_INIT;
            count_reg     <= '0;
        end
        else if (accept) begin
            phase_reg     <= phase_next;
            prev_hash_reg <= prev_hash_next;
            prev_cr_reg   <= prev_cr_next;
            digits_reg    <= digits_next;
            len_val_reg   <= len_val_next;
            len_stop_reg  <= len_stop_next;
            fill_reg      <= fill_next;
            crc_reg       <= crc_next;
            count_reg     <= count_next;
        end
    end

    // Delay window; fill_reg decides when its contents count.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            for (int i = 0; i < WIN; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    // Output register with skid stage.
    hj212frc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept && res_valid),
        .in_item   (res_item),
        .in_ready  (buf_ready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (buf_item)
    );

    // Pack the result transaction onto the stream ports.
    assign m_tdata = {4'b0000, buf_item.computed_crc, buf_item.received_crc,
                      buf_item.data_length, buf_item.declared_length,
                      buf_item.status, buf_item.payload_byte};
    assign m_tuser = buf_item.kind;
    assign m_tlast = buf_item.last;

endmodule

`default_nettype wire
